@@ rtl/core/llws_pkg.sv @@
`default_nettype none

package llws_pkg;

   // Sizing of the counter bank
   localparam int MAX_WORKERS = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int WIDX_W      = $clog2(MAX_WORKERS);
   localparam int NEFF_W      = WIDX_W + 1;
   localparam int CFG_W       = 5;
   localparam int HASH_W      = 32;
   localparam int STEP_W      = $clog2(HASH_W);
   localparam int STATUS_W    = 2;

   // Action codes
   localparam logic ACT_ACQUIRE = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

   // Microprogram addresses
   localparam int PC_W = 3;
   localparam logic [PC_W-1:0] PC_WAIT     = 3'd0;
   localparam logic [PC_W-1:0] PC_DISPATCH = 3'd1;
   localparam logic [PC_W-1:0] PC_MODE     = 3'd2;
   localparam logic [PC_W-1:0] PC_SCAN     = 3'd3;
   localparam logic [PC_W-1:0] PC_ACQUIRE  = 3'd4;
   localparam logic [PC_W-1:0] PC_MOD      = 3'd5;
   localparam logic [PC_W-1:0] PC_TAKE_REM = 3'd6;
   localparam logic [PC_W-1:0] PC_RELEASE  = 3'd7;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LATCH,
      OP_SCAN_STEP,
      OP_MOD_STEP,
      OP_TAKE_REM,
      OP_ACQUIRE,
      OP_RELEASE
   } op_type;

   typedef enum logic [2:0] {
      JC_NEXT,
      JC_ALWAYS,
      JC_NO_START,
      JC_RELEASE,
      JC_HINT,
      JC_MOD_MORE,
      JC_SCAN_MORE
   } jcond_type;

   typedef struct packed {
      op_type           op;
      jcond_type        cond;
      logic [PC_W-1:0]  target;
   } ctrl_word_type;

   // Control store: one word per microprogram step
   function automatic ctrl_word_type ucode_word(input logic [PC_W-1:0] pc);
      ctrl_word_type cw;
      cw = '{op: OP_NOP, cond: JC_ALWAYS, target: PC_WAIT};
      case (pc)
         PC_WAIT:     cw = '{op: OP_LATCH,     cond: JC_NO_START,  target: PC_WAIT};
         PC_DISPATCH: cw = '{op: OP_NOP,       cond: JC_RELEASE,   target: PC_RELEASE};
         PC_MODE:     cw = '{op: OP_NOP,       cond: JC_HINT,      target: PC_MOD};
         PC_SCAN:     cw = '{op: OP_SCAN_STEP, cond: JC_SCAN_MORE, target: PC_SCAN};
         PC_ACQUIRE:  cw = '{op: OP_ACQUIRE,   cond: JC_ALWAYS,    target: PC_WAIT};
         PC_MOD:      cw = '{op: OP_MOD_STEP,  cond: JC_MOD_MORE,  target: PC_MOD};
         PC_TAKE_REM: cw = '{op: OP_TAKE_REM,  cond: JC_ALWAYS,    target: PC_ACQUIRE};
         PC_RELEASE:  cw = '{op: OP_RELEASE,   cond: JC_ALWAYS,    target: PC_WAIT};
         default:     cw = '{op: OP_NOP,       cond: JC_ALWAYS,    target: PC_WAIT};
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/least_loaded_worker_selector.sv @@
`default_nettype none

// Least-loaded worker selector. Pulse start while busy is low to hand in one
// request word (acquire or release); the block then raises busy and, when done,
// presents exactly one result word on the rsp_ ports for a single cycle marked
// by rsp_valid. The receiver cannot stall: it must take the word in that cycle.
// A microprogram of eight steps sequences the work, so the time per request is
// set by its loops: a release runs the dispatch and release steps, an acquire
// without a hash runs dispatch, mode, the scan loop over the n workers in use
// (one counter examined per cycle) and the acquire step, and an acquire with a
// hash runs dispatch, mode, the remainder loop (the remainder is formed one
// hash bit per cycle), take-remainder and acquire. A new request is taken only
// while busy is low. Counters are cleared by reset. Write worker_count on the
// csr_ port only while the block is idle; it is always ready.
module least_loaded_worker_selector import llws_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_action,
   input  logic                   req_hint_present,
   input  logic [HASH_W-1:0]      req_hint_hash,
   input  logic [WIDX_W-1:0]      req_worker_index,
   output logic                   rsp_valid,
   output logic [WIDX_W-1:0]      rsp_selected_worker,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [COUNT_WIDTH-1:0] rsp_load_after,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_W-1:0]       csr_worker_count
);

   // Sequencer
   logic [PC_W-1:0]  upc_ff, upc_in;
   ctrl_word_type    cw;
   logic             jump;

   // Configuration
   logic [CFG_W-1:0]  cfg_ff;
   logic [NEFF_W-1:0] n_eff;
   logic [NEFF_W-1:0] n_last;

   // Latched request word
   logic              action_ff, action_in;
   logic              hint_ff, hint_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [WIDX_W-1:0] idx_ff, idx_in;

   // Datapath working registers
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [WIDX_W-1:0]      rem_ff, rem_in;
   logic [WIDX_W-1:0]      sel_ff, sel_in;
   logic [COUNT_WIDTH-1:0] best_ff, best_in;
   logic [NEFF_W-1:0]      rem_sh;

   // Counter bank, single read port
   logic [COUNT_WIDTH-1:0] cnt_ff [MAX_WORKERS];
   logic [WIDX_W-1:0]      rd_addr;
   logic [COUNT_WIDTH-1:0] rd_data;
   logic                   cnt_we;
   logic [COUNT_WIDTH-1:0] cnt_in;

   // Result registers
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WIDX_W-1:0]      rsp_sel_ff, rsp_sel_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [COUNT_WIDTH-1:0] rsp_load_ff, rsp_load_in;

   logic accept;

   assign cw        = ucode_word(upc_ff);
   assign busy      = (upc_ff != PC_WAIT);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Clamp the worker count to 1..MAX_WORKERS
   always_comb begin
      if (cfg_ff == '0) begin
         n_eff = NEFF_W'(1);
      end else if (cfg_ff > CFG_W'(MAX_WORKERS)) begin
         n_eff = NEFF_W'(MAX_WORKERS);
      end else begin
         n_eff = NEFF_W'(cfg_ff);
      end
   end
   assign n_last = n_eff - 1'b1;

   // Jump condition
   always_comb begin
      case (cw.cond)
         JC_NEXT:      jump = 1'b0;
         JC_ALWAYS:    jump = 1'b1;
         JC_NO_START:  jump = !start;
         JC_RELEASE:   jump = (action_ff == ACT_RELEASE);
         JC_HINT:      jump = hint_ff;
         JC_MOD_MORE:  jump = (step_ff != STEP_W'(HASH_W - 1));
         JC_SCAN_MORE: jump = (step_ff != STEP_W'(n_last));
         default:      jump = 1'b0;
      endcase
      upc_in = jump ? cw.target : upc_ff + 1'b1;
   end

   // Read address follows the step being run
   always_comb begin
      case (cw.op)
         OP_SCAN_STEP: rd_addr = step_ff[WIDX_W-1:0];
         OP_RELEASE:   rd_addr = idx_ff;
         default:      rd_addr = sel_ff;
      endcase
   end
   assign rd_data = cnt_ff[rd_addr];

   // Remainder step: shift in the next hash bit, subtract n when it fits
   assign rem_sh = {rem_ff, hash_ff[HASH_W-1]};

   always_comb begin
      action_in     = action_ff;
      hint_in       = hint_ff;
      hash_in       = hash_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      rem_in        = rem_ff;
      sel_in        = sel_ff;
      best_in       = best_ff;
      cnt_we        = 1'b0;
      cnt_in        = rd_data;
      rsp_valid_in  = 1'b0;
      rsp_sel_in    = rsp_sel_ff;
      rsp_status_in = rsp_status_ff;
      rsp_load_in   = rsp_load_ff;

      case (cw.op)
         OP_LATCH: begin
            if (accept) begin
               action_in = req_action;
               hint_in   = req_hint_present;
               hash_in   = req_hint_hash;
               idx_in    = req_worker_index;
               step_in   = '0;
               rem_in    = '0;
            end
         end
         OP_SCAN_STEP: begin
            // keep the first strictly smaller count: lowest index wins a tie
            if (step_ff == '0 || rd_data < best_ff) begin
               best_in = rd_data;
               sel_in  = step_ff[WIDX_W-1:0];
            end
            step_in = step_ff + 1'b1;
         end
         OP_MOD_STEP: begin
            if (rem_sh >= n_eff) begin
               rem_in = WIDX_W'(rem_sh - n_eff);
            end else begin
               rem_in = rem_sh[WIDX_W-1:0];
            end
            hash_in = {hash_ff[HASH_W-2:0], 1'b0};
            step_in = step_ff + 1'b1;
         end
         OP_TAKE_REM: begin
            sel_in = rem_ff;
         end
         OP_ACQUIRE: begin
            rsp_valid_in = 1'b1;
            rsp_sel_in   = sel_ff;
            if (rd_data == '1) begin
               rsp_status_in = ST_SATURATED;
               rsp_load_in   = rd_data;
            end else begin
               cnt_we        = 1'b1;
               cnt_in        = rd_data + 1'b1;
               rsp_status_in = ST_DONE;
               rsp_load_in   = rd_data + 1'b1;
            end
         end
         OP_RELEASE: begin
            rsp_valid_in = 1'b1;
            rsp_sel_in   = idx_ff;
            if ({1'b0, idx_ff} >= n_eff || rd_data == '0) begin
               rsp_status_in = ST_IGNORED;
               rsp_load_in   = '0;
            end else begin
               cnt_we        = 1'b1;
               cnt_in        = rd_data - 1'b1;
               rsp_status_in = ST_DONE;
               rsp_load_in   = rd_data - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= PC_WAIT;
         cfg_ff       <= CFG_W'(MAX_WORKERS);
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_worker_count;
         end
      end
   end

   // Counter bank: cleared by reset, at most one write per step
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_WORKERS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cnt_we) begin
         cnt_ff[rd_addr] <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      hint_ff       <= hint_in;
      hash_ff       <= hash_in;
      idx_ff        <= idx_in;
      step_ff       <= step_in;
      rem_ff        <= rem_in;
      sel_ff        <= sel_in;
      best_ff       <= best_in;
      rsp_sel_ff    <= rsp_sel_in;
      rsp_status_ff <= rsp_status_in;
      rsp_load_ff   <= rsp_load_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_selected_worker = rsp_sel_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_load_after      = rsp_load_ff;

   // A result only comes out of an acquire or release step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(upc_ff) == PC_ACQUIRE || $past(upc_ff) == PC_RELEASE))
      else $error("result strobe without acquire or release step");

   // The sequencer is back at rest whenever a result is shown
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while sequencer busy");

   // An accepted request always makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start the sequencer");

   // An ignored release reports zero load
   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_IGNORED) |-> (rsp_load_after == '0))
      else $error("ignored release with nonzero load");

   // A saturated acquire reports a full counter
   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_SATURATED) |-> (rsp_load_after == '1))
      else $error("saturated acquire without full counter");

endmodule

`default_nettype wire

@@ sim/tb_least_loaded_worker_selector.sv @@
`timescale 1ns / 100ps

module tb_least_loaded_worker_selector import llws_pkg::*; ();

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam int MAX_PRINTED = 40;

   // One result word as the block presents it
   typedef struct packed {
      logic [WIDX_W-1:0]      worker;
      logic [STATUS_W-1:0]    status;
      logic [COUNT_WIDTH-1:0] load;
   } grant_word_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_action;
   logic                   req_hint_present;
   logic [HASH_W-1:0]      req_hint_hash;
   logic [WIDX_W-1:0]      req_worker_index;
   logic                   rsp_valid;
   logic [WIDX_W-1:0]      rsp_selected_worker;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_WIDTH-1:0] rsp_load_after;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CFG_W-1:0]       csr_worker_count;

   // Mirror of the block's counter bank and its worker_count register
   logic [COUNT_WIDTH-1:0] load_mirror [MAX_WORKERS];
   logic [CFG_W-1:0]       worker_count_mirror;

   // Expected result words, oldest first
   grant_word_type grant_queue [$];

   int  error_count;
   bit  gaps_on;
   int  n_hint_acq, n_scan_acq, n_released, n_ignored, n_saturated, n_csr_writes;

   least_loaded_worker_selector u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_hint_present    (req_hint_present),
      .req_hint_hash       (req_hint_hash),
      .req_worker_index    (req_worker_index),
      .rsp_valid           (rsp_valid),
      .rsp_selected_worker (rsp_selected_worker),
      .rsp_status          (rsp_status),
      .rsp_load_after      (rsp_load_after),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_worker_count    (csr_worker_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Clamp the register to the workers actually in use: 0 acts as 1, above
   // the bank size acts as the bank size.
   function automatic int eff_workers(input logic [CFG_W-1:0] wc);
      int n;
      n = int'(wc);
      if (n == 0)
         n = 1;
      if (n > MAX_WORKERS)
         n = MAX_WORKERS;
      return n;
   endfunction

   // Apply one request word to the mirror and return the word the block owes.
   function automatic grant_word_type predict_grant(input logic act, input logic hint,
                                                    input logic [HASH_W-1:0] hash,
                                                    input logic [WIDX_W-1:0] idx);
      grant_word_type    g;
      int                n;
      int                pick;
      logic [HASH_W-1:0] n_wide;
      n      = eff_workers(worker_count_mirror);
      n_wide = HASH_W'(n);
      g.status = ST_DONE;
      g.load   = '0;
      if (act == ACT_RELEASE) begin
         g.worker = idx;
         // Out-of-range index or empty counter: leave the bank alone
         if (int'(idx) >= n || load_mirror[idx] == '0) begin
            g.status = ST_IGNORED;
         end else begin
            load_mirror[idx] = load_mirror[idx] - 1'b1;
            g.load = load_mirror[idx];
         end
      end else begin
         if (hint) begin
            pick = int'(hash % n_wide);
         end else begin
            // Lowest count wins; strict compare keeps the lowest index on a tie
            pick = 0;
            for (int i = 1; i < n; i++)
               if (load_mirror[i] < load_mirror[pick])
                  pick = i;
         end
         g.worker = WIDX_W'(pick);
         if (load_mirror[pick] == COUNT_MAX)
            g.status = ST_SATURATED;
         else
            load_mirror[pick] = load_mirror[pick] + 1'b1;
         g.load = load_mirror[pick];
      end
      return g;
   endfunction

   task automatic report_mismatch(input string what, input longint want_v,
                                  input longint got_v);
      if (error_count < MAX_PRINTED)
         $display("%0t: MISMATCH %s: expected %0d, got %0d", $time, what, want_v, got_v);
      error_count++;
   endtask

   // Watch both channels at the rising edge; all values here are pre-update.
   always @(posedge clock) begin : result_monitor
      grant_word_type want;
      grant_word_type got;
      if (reset) begin
         for (int i = 0; i < MAX_WORKERS; i++)
            load_mirror[i] = '0;
         worker_count_mirror = CFG_W'(16);
      end else begin
         // Check the result word first: it can never belong to a word taken
         // at this same edge.
         if (rsp_valid === 1'b1) begin
            got = '{worker: rsp_selected_worker, status: rsp_status, load: rsp_load_after};
            if (grant_queue.size() == 0) begin
               report_mismatch("result word with nothing pending", -1, longint'(got));
            end else begin
               want = grant_queue.pop_front();
               if (got.worker !== want.worker)
                  report_mismatch("selected_worker", longint'(want.worker),
                                  longint'(got.worker));
               if (got.status !== want.status)
                  report_mismatch("status", longint'(want.status), longint'(got.status));
               if (got.load !== want.load)
                  report_mismatch("load_after", longint'(want.load), longint'(got.load));
            end
         end
         if (csr_valid && csr_ready) begin
            worker_count_mirror = csr_worker_count;
            n_csr_writes++;
         end
         if (start && !busy) begin
            want = predict_grant(req_action, req_hint_present, req_hint_hash,
                                 req_worker_index);
            grant_queue.insert(grant_queue.size(), want);
            if (req_action == ACT_RELEASE) begin
               if (want.status == ST_IGNORED)
                  n_ignored++;
               else
                  n_released++;
            end else begin
               if (req_hint_present)
                  n_hint_acq++;
               else
                  n_scan_acq++;
               if (want.status == ST_SATURATED)
                  n_saturated++;
            end
         end
      end
   end

   // Hand in one request word. Start stays high on return so that a word sent
   // right after goes in back to back; any other caller drops it first.
   task automatic send_req(input logic act, input logic hint,
                           input logic [HASH_W-1:0] hash,
                           input logic [WIDX_W-1:0] idx);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      start            <= 1'b1;
      req_action       <= act;
      req_hint_present <= hint;
      req_hint_hash    <= hash;
      req_worker_index <= idx;
      // Hold until the edge that takes the word
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Drop start and wait until every expected word is back and the block idles.
   task automatic drain_results();
      start <= 1'b0;
      do @(negedge clock); while (grant_queue.size() != 0 || busy);
   endtask

   // Write worker_count, only from idle
   task automatic write_worker_count(input logic [CFG_W-1:0] value);
      drain_results();
      csr_valid        <= 1'b1;
      csr_worker_count <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Reset value of the register, ties in the scan, hash extremes, release at zero
   task automatic test_reset_defaults();
      send_req(ACT_ACQUIRE, 1'b0, '0, '0);
      send_req(ACT_ACQUIRE, 1'b0, '1, '1);
      send_req(ACT_RELEASE, 1'b1, '1, WIDX_W'(0));
      send_req(ACT_RELEASE, 1'b0, '0, WIDX_W'(0));
      send_req(ACT_RELEASE, 1'b0, '0, WIDX_W'(15));
      send_req(ACT_ACQUIRE, 1'b1, '1, '0);
      send_req(ACT_ACQUIRE, 1'b1, '0, '1);
   endtask

   // Zero count acts as one, oversized counts act as the bank size
   task automatic test_count_extremes();
      write_worker_count(CFG_W'(0));
      send_req(ACT_ACQUIRE, 1'b1, 32'h1234_5677, '0);
      send_req(ACT_RELEASE, 1'b0, '0, WIDX_W'(1));
      send_req(ACT_ACQUIRE, 1'b0, '0, '0);
      write_worker_count('1);
      send_req(ACT_RELEASE, 1'b0, '0, WIDX_W'(15));
      send_req(ACT_ACQUIRE, 1'b1, 32'hDEAD_BEEF, '0);
      write_worker_count(CFG_W'(17));
      send_req(ACT_ACQUIRE, 1'b0, '0, '0);
   endtask

   // Counters past a shrunk count are kept but are out of reach until it grows
   task automatic test_shrunk_count();
      write_worker_count(CFG_W'(16));
      send_req(ACT_ACQUIRE, 1'b1, 32'd5, '0);
      send_req(ACT_ACQUIRE, 1'b1, 32'd5, '0);
      write_worker_count(CFG_W'(3));
      send_req(ACT_RELEASE, 1'b0, '0, WIDX_W'(5));
      send_req(ACT_ACQUIRE, 1'b0, '0, '0);
      send_req(ACT_ACQUIRE, 1'b0, '0, '0);
      send_req(ACT_ACQUIRE, 1'b1, '1, '0);
      write_worker_count(CFG_W'(7));
      send_req(ACT_ACQUIRE, 1'b1, 32'h8000_0000, '0);
      write_worker_count(CFG_W'(16));
      send_req(ACT_RELEASE, 1'b0, '0, WIDX_W'(5));
   endtask

   // Random traffic in phases of different worker counts. Most releases target
   // a live worker so counts rise and fall; the rest are random noise.
   task automatic test_random_traffic(input int items_per_phase);
      logic [CFG_W-1:0]  plan [6];
      logic [HASH_W-1:0] hash;
      logic [WIDX_W-1:0] idx;
      int                kind;
      int                n;
      int                base;
      int                drain_at;
      bit                found;
      plan = '{CFG_W'(16), CFG_W'(1), CFG_W'(9), CFG_W'(31), CFG_W'(2), CFG_W'(0)};
      plan[5] = CFG_W'($urandom_range(0, 31));
      for (int ph = 0; ph < 6; ph++) begin
         write_worker_count(plan[ph]);
         drain_at = $urandom_range(10, items_per_phase - 10);
         for (int it = 0; it < items_per_phase; it++) begin
            // Toggle idling in stretches; keep the last phase free of it
            if (it % 50 == 0)
               gaps_on = (ph < 5) && ($urandom_range(0, 3) != 0);
            if (it == drain_at)
               drain_results();
            kind = $urandom_range(0, 9);
            hash = $urandom;
            if ($urandom_range(0, 4) == 0)
               hash = HASH_W'($urandom_range(0, 40));
            idx  = WIDX_W'($urandom_range(0, 15));
            if (kind < 5) begin
               send_req(ACT_ACQUIRE, 1'($urandom_range(0, 1)), hash, idx);
            end else begin
               if (kind < 9) begin
                  n     = eff_workers(worker_count_mirror);
                  base  = $urandom_range(0, n - 1);
                  found = 1'b0;
                  for (int k = 0; k < n; k++)
                     if (!found && load_mirror[(base + k) % n] != '0) begin
                        idx   = WIDX_W'((base + k) % n);
                        found = 1'b1;
                     end
               end
               send_req(ACT_RELEASE, 1'($urandom_range(0, 1)), hash, idx);
            end
         end
      end
      gaps_on = 1'b0;
   endtask

   // Pile acquires on worker 0 with one worker in use, then spread out again
   task automatic test_heavy_worker();
      gaps_on = 1'b0;
      write_worker_count(CFG_W'(1));
      for (int k = 0; k < 40; k++)
         send_req(ACT_ACQUIRE, 1'b0, '0, '0);
      send_req(ACT_ACQUIRE, 1'b1, 32'hFFFF_FFF0, '0);
      write_worker_count(CFG_W'(16));
      send_req(ACT_ACQUIRE, 1'b1, 32'h10, '0);
      send_req(ACT_RELEASE, 1'b0, '0, WIDX_W'(0));
      send_req(ACT_ACQUIRE, 1'b0, '0, '0);
      send_req(ACT_ACQUIRE, 1'b1, 32'h20, '0);
      send_req(ACT_ACQUIRE, 1'b1, 32'h30, '0);
   endtask

   initial begin
      // Drive every input to a known value from time zero
      reset            = 1'b1;
      start            = 1'b0;
      req_action       = ACT_ACQUIRE;
      req_hint_present = 1'b0;
      req_hint_hash    = '0;
      req_worker_index = '0;
      csr_valid        = 1'b0;
      csr_worker_count = '0;
      error_count      = 0;
      gaps_on          = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_count_extremes();
      test_shrunk_count();
      test_random_traffic(250);
      test_heavy_worker();

      // Wait out the tail and watch for stray result words
      drain_results();
      repeat (50) @(negedge clock);
      if (grant_queue.size() != 0)
         report_mismatch("result words never returned", 0, longint'(grant_queue.size()));

      $display("Covered %0d hashed and %0d least-loaded acquires (%0d saturated),",
               n_hint_acq, n_scan_acq, n_saturated);
      $display("%0d releases, %0d ignored releases, %0d worker_count writes; %0d errors.",
               n_released, n_ignored, n_csr_writes, error_count);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #50_000_000;
      $display("Watchdog expired with %0d words outstanding", grant_queue.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
